// ----- rtl/rgbspi_pkg.sv -----
// Shared types and constants for the RGB LED chain SPI byte encoder.
`timescale 1ns / 1ps
`default_nettype none
package rgbspi_pkg;

    // Operation codes of a command transfer
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LED_COUNT    = 2'd0;
    localparam logic [1:0] CFG_ZERO_PATTERN = 2'd1;
    localparam logic [1:0] CFG_ONE_PATTERN  = 2'd2;
    localparam logic [1:0] CFG_GAP_BYTES    = 2'd3;

    localparam int CFG_DATA_W  = 9;
    localparam int COUNT_REG_W = 9;

    // Register reset values
    localparam logic [8:0] RST_LED_COUNT    = 9'd0;
    localparam logic [7:0] RST_ZERO_PATTERN = 8'b1100_0000;
    localparam logic [7:0] RST_ONE_PATTERN  = 8'b1111_1100;
    localparam logic [7:0] RST_GAP_BYTES    = 8'd72;

    // Last bit position of one LED (24 bits, GRB)
    localparam logic [4:0] LAST_BIT = 5'd23;

    // What stage 2 puts on the wire
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_GAP    = 2'd1;
    localparam logic [1:0] KIND_COLOUR = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] channel_mask;
    } cmd_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] spi_byte;
        logic       frame_last;
        logic       busy_res;
        logic       accepted;
    } rsp_t;

    // Decision carried from stage 1 to stage 2
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] bit_pos;
        logic       last;
        logic       busy;
        logic       acc;
    } stage_t;

endpackage
`default_nettype wire

// ----- rtl/rgbspi_cmd_if.sv -----
// Command channel interface: valid/ready plus one command item.
`timescale 1ns / 1ps
`default_nettype none
interface rgbspi_cmd_if
    import rgbspi_pkg::*;
;
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rgbspi_rsp_if.sv -----
// Result channel interface: valid/ready plus one result item.
`timescale 1ns / 1ps
`default_nettype none
interface rgbspi_rsp_if
    import rgbspi_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rgb_led_chain_spi_byte_encoder.sv -----
// A command transfer passes the input register, the store read and the output register before its result appears.
// Throughput: one command per cycle; each stage moves when the one after it is empty or moving.
// The color store is read, with registered read data, each time a command leaves stage 1.
// Reset: control state clears and the configuration registers take their reset values at once; then the color store
// is zeroed, one entry per cycle over all MAX_LEDS entries, and no command is taken until that pass ends.
`timescale 1ns / 1ps
`default_nettype none
module rgb_led_chain_spi_byte_encoder
    import rgbspi_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    rgbspi_cmd_if.sink                 cmd,
    rgbspi_rsp_if.source               rsp
);

    localparam int AW     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW_MIN = $clog2(MAX_LEDS + 1);
    localparam int CW     = (CW_MIN > COUNT_REG_W) ? CW_MIN : COUNT_REG_W;
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_LEDS);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAX_LEDS - 1);

    // Configuration registers
    logic [8:0] led_count_reg;
    logic [7:0] zero_pat_reg;
    logic [7:0] one_pat_reg;
    logic [7:0] gap_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= RST_LED_COUNT;
            zero_pat_reg  <= RST_ZERO_PATTERN;
            one_pat_reg   <= RST_ONE_PATTERN;
            gap_bytes_reg <= RST_GAP_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LED_COUNT:    led_count_reg <= cfg_data[8:0];
                CFG_ZERO_PATTERN: zero_pat_reg  <= cfg_data[7:0];
                CFG_ONE_PATTERN:  one_pat_reg   <= cfg_data[7:0];
                CFG_GAP_BYTES:    gap_bytes_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Effective LED count, clamped to the store depth
    logic [CW-1:0] led_cnt_ext;
    logic [CW-1:0] eff_count;
    assign led_cnt_ext = CW'(led_count_reg);
    assign eff_count   = (led_cnt_ext > MAX_CNT) ? MAX_CNT : led_cnt_ext;

    // Store clearing pass after reset
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADR)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Pipeline flow control
    logic   s1_valid_reg;
    cmd_t   s1_reg;
    logic   s2_valid_reg;
    stage_t s2_reg;
    logic   rsp_valid_reg;
    rsp_t   rsp_reg;

    logic out_free, s2_free, s1_free;
    logic cmd_fire, s1_fire, s2_fire;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign cmd.ready = s1_free && !clr_active_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign s1_fire   = s1_valid_reg && s2_free;
    assign s2_fire   = s2_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd_fire || (s1_valid_reg && !s1_fire);
            s2_valid_reg  <= s1_fire || (s2_valid_reg && !s2_fire);
            rsp_valid_reg <= s2_fire || (rsp_valid_reg && !rsp.ready);
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_reg <= cmd.data;
        end
    end

    // Frame state
    logic          sending_reg, sending_next;
    logic [7:0]    gap_cnt_reg, gap_cnt_next;
    logic [CW-1:0] led_pos_reg, led_pos_next;
    logic [4:0]    bit_pos_reg, bit_pos_next;
    stage_t        s2_next;
    logic          wr_ok;
    logic [CW-1:0] led_pos_inc;

    assign led_pos_inc = led_pos_reg + 1'b1;

    // Stage 1: decide what the command does and advance the frame counters
    always_comb
    begin
        sending_next    = sending_reg;
        gap_cnt_next    = gap_cnt_reg;
        led_pos_next    = led_pos_reg;
        bit_pos_next    = bit_pos_reg;
        wr_ok           = 1'b0;
        s2_next.kind    = KIND_NONE;
        s2_next.bit_pos = bit_pos_reg;
        s2_next.last    = 1'b0;
        s2_next.acc     = 1'b0;

        case (s1_reg.operation)
            OP_WRITE:
            begin
                if (!sending_reg && (CW'(s1_reg.led_index) < eff_count))
                begin
                    wr_ok       = 1'b1;
                    s2_next.acc = 1'b1;
                end
            end
            OP_REFRESH:
            begin
                if (!sending_reg && (eff_count != '0))
                begin
                    sending_next = 1'b1;
                    gap_cnt_next = '0;
                    led_pos_next = '0;
                    bit_pos_next = '0;
                    s2_next.acc  = 1'b1;
                end
            end
            OP_REQUEST:
            begin
                if (sending_reg)
                begin
                    if (gap_cnt_reg < gap_bytes_reg)
                    begin
                        s2_next.kind = KIND_GAP;
                        gap_cnt_next = gap_cnt_reg + 1'b1;
                    end
                    else if (led_pos_reg >= eff_count)
                    begin
                        // count shrank under the frame: end with no byte
                        sending_next = 1'b0;
                    end
                    else
                    begin
                        s2_next.kind = KIND_COLOUR;
                        if (bit_pos_reg == LAST_BIT)
                        begin
                            bit_pos_next = '0;
                            led_pos_next = led_pos_inc;
                            if (led_pos_inc >= eff_count)
                            begin
                                s2_next.last = 1'b1;
                                sending_next = 1'b0;
                            end
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        s2_next.busy = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            gap_cnt_reg <= '0;
            led_pos_reg <= '0;
            bit_pos_reg <= '0;
        end
        else if (s1_fire)
        begin
            sending_reg <= sending_next;
            gap_cnt_reg <= gap_cnt_next;
            led_pos_reg <= led_pos_next;
            bit_pos_reg <= bit_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_reg <= s2_next;
        end
    end

    // Color store: one RAM per channel so the channel mask is a write enable
    logic          we_r, we_g, we_b;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    wd_r, wd_g, wd_b;
    logic [7:0]    rd_r, rd_g, rd_b;
    logic          wr_fire;

    assign wr_fire   = s1_fire && wr_ok;
    assign we_r      = clr_active_reg || (wr_fire && s1_reg.channel_mask[0]);
    assign we_g      = clr_active_reg || (wr_fire && s1_reg.channel_mask[1]);
    assign we_b      = clr_active_reg || (wr_fire && s1_reg.channel_mask[2]);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : AW'(s1_reg.led_index);
    assign wd_r      = clr_active_reg ? 8'd0 : s1_reg.red;
    assign wd_g      = clr_active_reg ? 8'd0 : s1_reg.green;
    assign wd_b      = clr_active_reg ? 8'd0 : s1_reg.blue;
    assign ram_raddr = led_pos_reg[AW-1:0];

    rgbspi_ram #(.WIDTH(8), .DEPTH(MAX_LEDS), .ADDR_W(AW)) u_ram_r (
        .clk   (clk),
        .we    (we_r),
        .waddr (ram_waddr),
        .wdata (wd_r),
        .re    (s1_fire),
        .raddr (ram_raddr),
        .rdata (rd_r)
    );

    rgbspi_ram #(.WIDTH(8), .DEPTH(MAX_LEDS), .ADDR_W(AW)) u_ram_g (
        .clk   (clk),
        .we    (we_g),
        .waddr (ram_waddr),
        .wdata (wd_g),
        .re    (s1_fire),
        .raddr (ram_raddr),
        .rdata (rd_g)
    );

    rgbspi_ram #(.WIDTH(8), .DEPTH(MAX_LEDS), .ADDR_W(AW)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (ram_waddr),
        .wdata (wd_b),
        .re    (s1_fire),
        .raddr (ram_raddr),
        .rdata (rd_b)
    );

    // Stage 2: pick the color bit (GRB, MSB first) and map it to a pattern byte
    logic [23:0] colour;
    logic [4:0]  bit_sel;
    rsp_t        rsp_next;

    assign colour  = {rd_g, rd_r, rd_b};
    assign bit_sel = LAST_BIT - s2_reg.bit_pos;

    always_comb
    begin
        rsp_next.byte_valid = 1'b0;
        rsp_next.spi_byte   = 8'd0;
        rsp_next.frame_last = s2_reg.last;
        rsp_next.busy_res   = s2_reg.busy;
        rsp_next.accepted   = s2_reg.acc;
        case (s2_reg.kind)
            KIND_GAP:
            begin
                rsp_next.byte_valid = 1'b1;
            end
            KIND_COLOUR:
            begin
                rsp_next.byte_valid = 1'b1;
                rsp_next.spi_byte   = colour[bit_sel] ? one_pat_reg : zero_pat_reg;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // Checks
    a_no_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !((we_r || we_g || we_b) && sending_reg))
        else $error("color store written while a frame is sending");

    a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !cmd.ready)
        else $error("command taken during store clearing");

    a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg <= LAST_BIT)
        else $error("bit position past the last color bit");

    a_led_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        led_pos_reg <= MAX_CNT)
        else $error("LED position beyond the store depth");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && s2_reg.last) |-> (s2_reg.kind == KIND_COLOUR) && !s2_reg.busy)
        else $error("frame end flagged on a non-color byte or while still busy");

endmodule
`default_nettype wire

// ----- rtl/rgbspi_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rgbspi_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the RGB LED chain SPI byte encoder: directed table, then random frames.
`timescale 1ns / 1ps
module tb_top;
    import rgbspi_pkg::*;

    localparam int         LEDS_MAX    = 256;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // Results that can be read straight off the command
    localparam rsp_t R_NONE  = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
    localparam rsp_t R_ACC   = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1};
    localparam rsp_t R_START = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1};
    localparam rsp_t R_BUSY  = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
    localparam rsp_t R_GAP   = '{1'b1, 8'h00, 1'b0, 1'b1, 1'b0};
    localparam rsp_t R_ONES  = '{1'b1, 8'hFF, 1'b0, 1'b1, 1'b0};

    // One row of the directed table: a register set or a command
    typedef struct packed {
        logic       is_cfg;
        logic [8:0] leds;
        logic [7:0] zpat;
        logic [7:0] opat;
        logic [7:0] gap;
        cmd_t       cmd;
        logic       typed;
        rsp_t       want;
    } step_t;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgbspi_cmd_if cmd();
    rgbspi_rsp_if rsp();

    // Typed expectation travelling with the command on the wire
    logic want_typed;
    rsp_t want_rsp;

    // Encoder image: color store, frame position and register copies
    logic [23:0] color_mem [LEDS_MAX];
    logic        frame_on;
    logic [7:0]  gap_sent;
    logic [8:0]  led_at;
    logic [4:0]  bit_at;
    logic [8:0]  reg_leds;
    logic [7:0]  reg_zero;
    logic [7:0]  reg_one;
    logic [7:0]  reg_gap;

    rsp_t rsp_due [$];
    int   mismatches = 0;
    int   burst_left = 0;
    int   cycles     = 0;
    logic [9:0] stall_tick = '0;

    rgb_led_chain_spi_byte_encoder #(
        .MAX_LEDS (LEDS_MAX)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side back-pressure: free, periodic, random and long stalls in turn
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0:    rsp.ready <= 1'b1;
            2'd1:    rsp.ready <= (stall_tick[2:0] != 3'b111);
            2'd2:    rsp.ready <= 1'($urandom_range(0, 1));
            default: rsp.ready <= (stall_tick[3:0] < 4'd5);
        endcase
    end

    // Next encoder result for one command; updates the encoder image
    function automatic rsp_t encode_cmd(cmd_t c);
        rsp_t        r;
        logic [23:0] grb;
        logic [4:0]  bp;
        logic [8:0]  n;
        r = '0;
        n = (reg_leds > 9'(LEDS_MAX)) ? 9'(LEDS_MAX) : reg_leds;
        case (c.operation)
            OP_WRITE:
                if (!frame_on && {1'b0, c.led_index} < n)
                begin
                    grb = color_mem[c.led_index];
                    if (c.channel_mask[0]) grb[15:8]  = c.red;
                    if (c.channel_mask[1]) grb[23:16] = c.green;
                    if (c.channel_mask[2]) grb[7:0]   = c.blue;
                    color_mem[c.led_index] = grb;
                    r.accepted = 1'b1;
                end
            OP_REFRESH:
                if (!frame_on && n != 0)
                begin
                    frame_on   = 1'b1;
                    gap_sent   = '0;
                    led_at     = '0;
                    bit_at     = '0;
                    r.accepted = 1'b1;
                end
            OP_REQUEST:
                if (frame_on)
                begin
                    if (gap_sent < reg_gap)
                    begin
                        r.byte_valid = 1'b1;
                        gap_sent     = gap_sent + 1'b1;
                    end
                    else if (led_at >= n)
                    begin
                        // count shrank under the frame: end with no byte
                        frame_on = 1'b0;
                    end
                    else
                    begin
                        grb          = color_mem[led_at[7:0]];
                        bp           = (bit_at > LAST_BIT) ? LAST_BIT : bit_at;
                        r.byte_valid = 1'b1;
                        r.spi_byte   = grb[LAST_BIT - bp] ? reg_one : reg_zero;
                        bit_at       = bp + 1'b1;
                        if (bit_at > LAST_BIT)
                        begin
                            bit_at = '0;
                            led_at = led_at + 1'b1;
                            if (led_at >= n)
                            begin
                                r.frame_last = 1'b1;
                                frame_on     = 1'b0;
                            end
                        end
                    end
                end
            default: ;
        endcase
        r.busy_res = frame_on;
        return r;
    endfunction

    // Scoreboard: check result transfers, predict command transfers, track register writes
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        rsp_t due;
        rsp_t calc;
        if (!rst_n)
        begin
            for (int i = 0; i < LEDS_MAX; i++)
                color_mem[i] = '0;
            frame_on = 1'b0;
            gap_sent = '0;
            led_at   = '0;
            bit_at   = '0;
            reg_leds = RST_LED_COUNT;
            reg_zero = RST_ZERO_PATTERN;
            reg_one  = RST_ONE_PATTERN;
            reg_gap  = RST_GAP_BYTES;
            rsp_due.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("result transfer with nothing expected: %p", rsp.data);
                    mismatches++;
                end
                else
                begin
                    due = rsp_due.pop_front();
                    if (rsp.data.byte_valid !== due.byte_valid)
                    begin
                        $error("byte_valid: expected %0d, got %0d",
                               due.byte_valid, rsp.data.byte_valid);
                        mismatches++;
                    end
                    if (rsp.data.spi_byte !== due.spi_byte)
                    begin
                        $error("spi_byte: expected %02h, got %02h",
                               due.spi_byte, rsp.data.spi_byte);
                        mismatches++;
                    end
                    if (rsp.data.frame_last !== due.frame_last)
                    begin
                        $error("frame_last: expected %0d, got %0d",
                               due.frame_last, rsp.data.frame_last);
                        mismatches++;
                    end
                    if (rsp.data.busy_res !== due.busy_res)
                    begin
                        $error("busy_res: expected %0d, got %0d",
                               due.busy_res, rsp.data.busy_res);
                        mismatches++;
                    end
                    if (rsp.data.accepted !== due.accepted)
                    begin
                        $error("accepted: expected %0d, got %0d",
                               due.accepted, rsp.data.accepted);
                        mismatches++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                calc = encode_cmd(cmd.data);
                rsp_due.push_back(want_typed ? want_rsp : calc);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LED_COUNT:    reg_leds = cfg_data[8:0];
                    CFG_ZERO_PATTERN: reg_zero = cfg_data[7:0];
                    CFG_ONE_PATTERN:  reg_one  = cfg_data[7:0];
                    CFG_GAP_BYTES:    reg_gap  = cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // One command transfer, with sender bursts and gaps; returns at a falling edge
    task automatic send_cmd(cmd_t c, logic typed, rsp_t want);
        int pause;
        if (burst_left == 0)
        begin
            pause = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (pause != 0)
            begin
                cmd.valid <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd.valid  <= 1'b1;
        cmd.data   <= c;
        want_typed <= typed;
        want_rsp   <= want;
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
    endtask

    // Hold off until every result is back and the pipeline has emptied
    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write all four registers, one per cycle
    task automatic set_config(logic [8:0] leds, logic [7:0] zpat, logic [7:0] opat,
                              logic [7:0] gap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LED_COUNT;
        cfg_data  <= CFG_DATA_W'(leds);
        @(negedge clk);
        cfg_index <= CFG_ZERO_PATTERN;
        cfg_data  <= CFG_DATA_W'(zpat);
        @(negedge clk);
        cfg_index <= CFG_ONE_PATTERN;
        cfg_data  <= CFG_DATA_W'(opat);
        @(negedge clk);
        cfg_index <= CFG_GAP_BYTES;
        cfg_data  <= CFG_DATA_W'(gap);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic cmd_t random_cmd(logic [1:0] op);
        cmd_t c;
        c.operation    = op;
        c.led_index    = 8'($urandom_range(0, 255));
        c.red          = 8'($urandom_range(0, 255));
        c.green        = 8'($urandom_range(0, 255));
        c.blue         = 8'($urandom_range(0, 255));
        c.channel_mask = 3'($urandom_range(0, 7));
        return c;
    endfunction

    function automatic logic [7:0] pick_pattern();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0)
            return 8'h00;
        if (k == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic step_t cfg_step(logic [8:0] leds, logic [7:0] zpat, logic [7:0] opat,
                                       logic [7:0] gap);
        step_t s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.leds   = leds;
        s.zpat   = zpat;
        s.opat   = opat;
        s.gap    = gap;
        return s;
    endfunction

    function automatic step_t op_step(logic [1:0] op, logic [7:0] idx, logic [7:0] r,
                                      logic [7:0] g, logic [7:0] b, logic [2:0] mask);
        step_t s;
        s     = '0;
        s.cmd = '{op, idx, r, g, b, mask};
        return s;
    endfunction

    function automatic step_t known(step_t s, rsp_t w);
        s.typed = 1'b1;
        s.want  = w;
        return s;
    endfunction

    // Stimulus
    initial
    begin
        step_t      plan [$];
        cmd_t       c;
        int         n;
        int         k;
        int         reqs;
        int         phase;
        int         sent;
        logic [8:0] leds;
        logic [7:0] gap;
        cmd.valid  = 1'b0;
        cmd.data   = '0;
        rsp.ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_LED_COUNT;
        cfg_data   = '0;
        want_typed = 1'b0;
        want_rsp   = '0;

        // Out of reset: empty chain, so nothing takes effect
        plan.push_back(known(op_step(OP_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00, 3'd7), R_NONE));
        plan.push_back(known(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_NONE));
        plan.push_back(known(op_step(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 3'd7), R_NONE));
        plan.push_back(known(op_step(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7), R_NONE));
        // Two LEDs, extreme patterns, no gap
        plan.push_back(cfg_step(9'd2, 8'h00, 8'hFF, 8'd0));
        plan.push_back(known(op_step(OP_WRITE, 8'd0, 8'h00, 8'hFF, 8'h80, 3'd7), R_ACC));
        plan.push_back(known(op_step(OP_WRITE, 8'd1, 8'hFF, 8'hFF, 8'hFF, 3'd0), R_ACC));
        plan.push_back(known(op_step(OP_WRITE, 8'd2, 8'hFF, 8'hFF, 8'hFF, 3'd7), R_NONE));
        plan.push_back(known(op_step(OP_WRITE, 8'd255, 8'h55, 8'hAA, 8'h55, 3'd7), R_NONE));
        plan.push_back(known(op_step(OP_WRITE, 8'd1, 8'hFF, 8'h01, 8'hFF, 3'd5), R_ACC));
        plan.push_back(known(op_step(OP_WRITE, 8'd1, 8'h00, 8'h7E, 8'h00, 3'd2), R_ACC));
        plan.push_back(known(op_step(OP_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_START));
        // Write and refresh while sending are dropped
        plan.push_back(known(op_step(OP_WRITE, 8'd0, 8'h12, 8'h34, 8'h56, 3'd7), R_BUSY));
        plan.push_back(known(op_step(OP_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_BUSY));
        plan.push_back(known(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_ONES));
        plan.push_back(known(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_ONES));
        plan.push_back(known(op_step(OP_UNUSED, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_BUSY));
        // New patterns mid-frame apply at once
        plan.push_back(cfg_step(9'd2, 8'h5A, 8'hA5, 8'd0));
        plan.push_back(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0));
        // Chain shrunk below the frame position: frame ends silently
        plan.push_back(cfg_step(9'd0, 8'h5A, 8'hA5, 8'd0));
        plan.push_back(known(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_NONE));
        plan.push_back(known(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_NONE));
        // Reset gap bytes ahead of the colors
        plan.push_back(cfg_step(9'd1, 8'hC0, 8'hFC, 8'd2));
        plan.push_back(known(op_step(OP_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_START));
        plan.push_back(known(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_GAP));
        plan.push_back(known(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0), R_GAP));
        plan.push_back(op_step(OP_REQUEST, 8'd0, 8'h00, 8'h00, 8'h00, 3'd0));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_drained();
                set_config(plan[i].leds, plan[i].zpat, plan[i].opat, plan[i].gap);
            end
            else
                send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
        end

        // Random frames: fill colors, refresh, pull the frame out, with noise mixed in
        sent  = 0;
        phase = 0;
        while (sent < 600)
        begin
            wait_drained();
            case (phase)
                1:
                begin
                    leds = 9'd511;
                    gap  = 8'd255;
                end
                3:
                begin
                    leds = 9'd256;
                    gap  = 8'd0;
                end
                default:
                begin
                    k    = $urandom_range(0, 9);
                    leds = (k == 0) ? 9'd0 :
                           (k == 1) ? 9'($urandom_range(5, 8)) : 9'($urandom_range(1, 3));
                    gap  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
                end
            endcase
            set_config(leds, pick_pattern(), pick_pattern(), gap);
            n = (leds > LEDS_MAX) ? LEDS_MAX : leds;

            // color writes, mostly in range, last LED now and then
            k = (n > 32) ? 12 : $urandom_range(0, 2 * n + 1);
            repeat (k)
            begin
                c = random_cmd(OP_WRITE);
                if (n > 0 && $urandom_range(0, 3) == 0)
                    c.led_index = 8'(n - 1);
                else if (n > 0 && $urandom_range(0, 7) != 0)
                    c.led_index = 8'($urandom_range(0, n - 1));
                send_cmd(c, 1'b0, R_NONE);
                sent++;
            end

            // refresh, left out now and then
            if ($urandom_range(0, 7) != 0)
            begin
                send_cmd(random_cmd(OP_REFRESH), 1'b0, R_NONE);
                sent++;
            end

            reqs = gap + 24 * n;
            if (phase == 1 && reqs > 290)
                reqs = 290;
            else if (reqs > 100)
                reqs = 100;
            reqs += $urandom_range(0, 3);
            repeat (reqs)
            begin
                if ($urandom_range(0, 11) == 0)
                    c = random_cmd(2'($urandom_range(0, 3)));
                else
                    c = random_cmd(OP_REQUEST);
                send_cmd(c, 1'b0, R_NONE);
                sent++;
            end
            phase++;
        end

        wait_drained();
        repeat (12) @(negedge clk);
        if (mismatches == 0 && rsp_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
